// ===== rtl/multi_channel_soft_timer_bank_unit_macros.svh =====
// Assertion macros for the soft timer bank
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_MACROS_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_UNIT_MACROS_SVH

// same-cycle implication
`define MCTB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MCTB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mctb_pkg.sv =====
// Package: types and constants of the soft timer bank
`default_nettype none
package mctb_pkg;

  localparam int TMR_NUM = 16;
  localparam int IDX_W   = $clog2(TMR_NUM);
  localparam int TW      = 32;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_SCAN  = 3'd1,
    REQ_START = 3'd2,
    REQ_STOP  = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_TIMEOUT = 2'd2
  } st_t;

  typedef enum logic {
    EV_TIMEOUT = 1'b0,
    EV_READ    = 1'b1
  } ev_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             en;
    logic             period_en;
    logic [IDX_W-1:0] addr;
    logic [TW-1:0]    match;
    logic [TW-1:0]    period;
  } mem_wr_t;

endpackage
`default_nettype wire

// ===== rtl/multi_channel_soft_timer_bank_unit.sv =====
// Top level: timer bank sequencer, status, tick counter and result register
// Tick, start, stop and read are handled in idle on acceptance; the read reply is registered.
// Scan walks every timer in turn through the shared adder/compare, then flushes the held
// last event; it is held up while the result register is stalled.
// A new item is accepted in idle when the result register is free.
// Synchronous active-low reset stops all timers, clears tick and periodic mask.
`default_nettype none
`include "multi_channel_soft_timer_bank_unit_macros.svh"
module multi_channel_soft_timer_bank_unit import mctb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_req_type,
  input  wire logic [IDX_W-1:0] in_timer_index,
  input  wire logic [TW-1:0]    in_delay_ticks,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_event_kind,
  output logic      [IDX_W-1:0] out_which_timer,
  output logic      [1:0]       out_timer_status,
  output logic                  out_last_of_run,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [15:0]      cfg_periodic_mask
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [15:0]      mask_r;
  st_t              status_r [TMR_NUM];
  st_t              st_wr_val;
  logic             st_wr_en;
  logic [IDX_W-1:0] st_addr;
  st_t              st_cur;
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_r, pend_nxt;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [IDX_W-1:0] out_which_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;
  logic             out_free;
  logic             push;
  logic             push_kind;
  logic [IDX_W-1:0] push_which;
  logic [1:0]       push_status;
  logic             push_last;

  logic [TW-1:0]    addend;
  logic [TW-1:0]    sum;
  logic             due;
  logic [TW-1:0]    rd_match, rd_period;
  logic [IDX_W-1:0] rd_addr;
  mem_wr_t          wr;
  logic             accept;
  logic             is_to;
  logic             stall;

  mctb_alu u_alu (
    .tick   (tick_r),
    .addend (addend),
    .match  (rd_match),
    .sum    (sum),
    .due    (due)
  );

  mctb_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_match  (rd_match),
    .rd_period (rd_period)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign st_addr   = (state_r == S_IDLE) ? in_timer_index : cnt_r;
  assign st_cur    = status_r[st_addr];
  assign is_to     = (state_r == S_SCAN) && (st_cur == ST_RUNNING) && due;
  assign stall     = ((state_r == S_SCAN) && is_to && pend_v_r && !out_free) ||
                     ((state_r == S_DONE) && pend_v_r && !out_free);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    tick_nxt    = tick_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    st_wr_en    = 1'b0;
    st_wr_val   = ST_STOPPED;
    addend      = rd_period;
    rd_addr     = cnt_r;
    wr          = '0;
    wr.addr     = st_addr;
    wr.match    = sum;
    wr.period   = in_delay_ticks;
    push        = 1'b0;
    push_kind   = EV_TIMEOUT;
    push_which  = pend_r;
    push_status = ST_TIMEOUT;
    push_last   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        addend  = (in_req_type == REQ_TICK) ? TW'(1) : in_delay_ticks;
        rd_addr = '0;
        if (accept) begin
          case (in_req_type)
            REQ_TICK: tick_nxt = sum;
            REQ_SCAN: begin
              cnt_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            REQ_START: begin
              wr.en        = 1'b1;
              wr.period_en = 1'b1;
              st_wr_en     = 1'b1;
              st_wr_val    = ST_RUNNING;
            end
            REQ_STOP: begin
              st_wr_en  = 1'b1;
              st_wr_val = ST_STOPPED;
            end
            REQ_READ: begin
              push        = 1'b1;
              push_kind   = EV_READ;
              push_which  = in_timer_index;
              push_status = st_cur;
              push_last   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          rd_addr = cnt_r + IDX_W'(1);
          if (is_to) begin
            st_wr_en   = 1'b1;
            st_wr_val  = ST_TIMEOUT;
            push       = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_nxt   = cnt_r;
          end else if (st_cur == ST_TIMEOUT) begin
            st_wr_en = 1'b1;
            if (mask_r[cnt_r]) begin
              st_wr_val = ST_RUNNING;
              wr.en     = 1'b1;
            end else begin
              st_wr_val = ST_STOPPED;
            end
          end
          cnt_nxt = cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(TMR_NUM - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!stall) begin
          push       = pend_v_r;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      tick_r   <= '0;
      pend_v_r <= 1'b0;
      mask_r   <= '0;
      for (int i = 0; i < TMR_NUM; i++) begin
        status_r[i] <= ST_STOPPED;
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      tick_r   <= tick_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_periodic_mask;
      end
      if (st_wr_en) begin
        status_r[st_addr] <= st_wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r   <= push_kind;
      out_which_r  <= push_which;
      out_status_r <= push_status;
      out_last_r   <= push_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_which_timer  = out_which_r;
  assign out_timer_status = out_status_r;
  assign out_last_of_run  = out_last_r;

  `MCTB_ASSERT_IMP(a_push_free, push, out_free)
  `MCTB_ASSERT_IMP(a_to_status, out_valid_r && (out_kind_r == EV_TIMEOUT),
                   out_status_r == ST_TIMEOUT)
  `MCTB_ASSERT_NXT(a_scan_start, accept && (in_req_type == REQ_SCAN),
                   (state_r == S_SCAN) && (cnt_r == '0) && !pend_v_r)
  `MCTB_ASSERT_NXT(a_done_flush, (state_r == S_DONE) && !stall,
                   !pend_v_r && (state_r == S_IDLE))

endmodule
`default_nettype wire

// ===== rtl/mctb_alu.sv =====
// Shared adder and match comparator
`default_nettype none
module mctb_alu import mctb_pkg::*; (
  input  wire logic [TW-1:0] tick,
  input  wire logic [TW-1:0] addend,
  input  wire logic [TW-1:0] match,
  output logic      [TW-1:0] sum,
  output logic               due
);

  assign sum = tick + addend;
  assign due = (match <= tick);

endmodule
`default_nettype wire

// ===== rtl/mctb_mem.sv =====
// Match and period storage, one write port, one registered read port
`default_nettype none
module mctb_mem import mctb_pkg::*; (
  input  wire logic             clk,
  input  wire mem_wr_t          wr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [TW-1:0]    rd_match,
  output logic      [TW-1:0]    rd_period
);

  logic [TW-1:0] match_mem  [TMR_NUM];
  logic [TW-1:0] period_mem [TMR_NUM];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      match_mem[wr.addr] <= wr.match;
    end
    if (wr.en && wr.period_en) begin
      period_mem[wr.addr] <= wr.period;
    end
    rd_match  <= match_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
  end

endmodule
`default_nettype wire
